FILE: rtl/pre_pkg.sv
package pre_pkg;

    typedef struct packed {
        logic [5:0] page;
        logic       is_write;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] frame;
        logic [5:0] evicted_page;
    } t_rsp;

    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_FREE    = 2'd1;
    localparam logic [1:0] ST_EVICT   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_PAGES  = 2'd1;
    localparam logic [1:0] CFG_FRAMES = 2'd2;
    localparam logic [1:0] CFG_PERIOD = 2'd3;

    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_SECOND = 2'd1;
    localparam logic [1:0] POL_NRU    = 2'd2;
    localparam logic [1:0] POL_AGING  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HIT,
        S_FIFO,
        S_FIFOW,
        S_SC_MOD,
        S_SC_RD,
        S_SC_CHK,
        S_NRU,
        S_AGE,
        S_EV_RD,
        S_EV_WR,
        S_OMOD,
        S_MAP,
        S_DONE
    } t_state;

endpackage

FILE: rtl/pre_ram.sv
module pre_ram
    import pre_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/page_replacement_engine.sv
// page replacement engine
// request channel: i_req_valid / o_req_ready carry one access (page, is_write).
// response channel: o_rsp_valid / i_rsp_ready carry one result per request
// (status, frame, evicted_page).
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (policy, pages in use, frames in use, tick period); write only when idle.
// path from acceptance to o_rsp_valid high: an invalid page goes straight
// to the result; a hit reads its frame from the page table; a fault into a
// free frame maps the page with no search; eviction adds the victim search:
// fifo reads the page in the oldest frame, second chance visits frames from
// the oldest one, nru and aging scan every valid page, and the oldest-frame
// pointer is then wrapped. one request is worked at a time; the page-table
// memories with one read port per cycle set the pace. after reset the block
// sweeps the age memory before the first request is accepted.
// a finished result sits in the output register; a stalled receiver holds
// it there while the next request may already be accepted and worked, and
// that request's result waits until the output register is free.
module page_replacement_engine
    import pre_pkg::*;
#(
    parameter int MAX_PAGES  = 64,
    parameter int MAX_FRAMES = 16,
    parameter int AGE_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int PW  = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
    localparam int FW  = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
    localparam int NPW = $clog2(MAX_PAGES + 1);
    localparam int NFW = $clog2(MAX_FRAMES + 1);

    t_state r_state, n_state;
    logic [1:0]  r_policy;
    logic [6:0]  r_pages;
    logic [4:0]  r_frames;
    logic [15:0] r_period;
    logic [15:0] r_acc, n_acc;
    logic [NFW-1:0] r_used, n_used;
    logic [FW-1:0]  r_next_free, n_next_free;
    logic [FW-1:0]  r_oldest, n_oldest;
    logic [MAX_PAGES-1:0] r_mapped, n_mapped, r_dirty, n_dirty, r_ref, n_ref;
    logic [PW-1:0]  r_page, n_page;
    logic           r_wr, n_wr;
    logic           r_tick, n_tick;
    logic [FW-1:0]  r_frame, n_frame;
    logic [PW-1:0]  r_v, n_v;
    logic [1:0]     r_stat, n_stat;
    logic [FW-1:0]  r_f, n_f;
    logic [NFW-1:0] r_cnt, n_cnt;
    logic [NPW-1:0] r_scan, n_scan;
    logic           r_pv, n_pv;
    logic [PW-1:0]  r_pp, n_pp;
    logic           r_found, n_found;
    logic [AGE_BITS-1:0] r_best, n_best;
    logic [PW-1:0]  r_bidx, n_bidx;
    logic [3:0]     r_nf, n_nf;
    logic [PW-1:0]  r_ni [4];
    logic [PW-1:0]  n_ni [4];
    logic [FW:0]    r_omod, n_omod;
    logic           r_out_valid, n_out_valid;
    t_rsp           r_out, n_out;
    t_rsp           r_res, n_res;

    logic [NPW-1:0] np;
    logic [NFW-1:0] nf;
    logic [16:0]    cnt;

    logic                fop_we, pof_we, age_we;
    logic [PW-1:0]       fop_waddr, fop_raddr, age_waddr, age_raddr, pof_wdata, pof_rdata;
    logic [FW-1:0]       fop_wdata, fop_rdata, pof_waddr, pof_raddr;
    logic [AGE_BITS-1:0] age_wdata, age_rdata, age_sum;
    logic [PW-1:0]       sp;

    pre_ram #(.DEPTH(MAX_PAGES), .WIDTH(FW)) u_fop (
        .i_clk(i_clk), .i_we(fop_we), .i_waddr(fop_waddr), .i_wdata(fop_wdata),
        .i_raddr(fop_raddr), .o_rdata(fop_rdata)
    );

    pre_ram #(.DEPTH(MAX_FRAMES), .WIDTH(PW)) u_pof (
        .i_clk(i_clk), .i_we(pof_we), .i_waddr(pof_waddr), .i_wdata(pof_wdata),
        .i_raddr(pof_raddr), .o_rdata(pof_rdata)
    );

    pre_ram #(.DEPTH(MAX_PAGES), .WIDTH(AGE_BITS)) u_age (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(age_waddr), .i_wdata(age_wdata),
        .i_raddr(age_raddr), .o_rdata(age_rdata)
    );

    assign np  = (int'(r_pages) > MAX_PAGES) ? NPW'(MAX_PAGES) : NPW'(r_pages);
    assign nf  = (r_frames == 5'd0) ? NFW'(1) :
                 ((int'(r_frames) > MAX_FRAMES) ? NFW'(MAX_FRAMES) : NFW'(r_frames));
    assign cnt = {1'b0, r_acc} + 17'd1;
    assign sp  = r_scan[PW-1:0];
    assign age_sum = age_rdata + AGE_BITS'(r_tick & r_ref[r_pp]);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        n_state = r_state; n_acc = r_acc; n_used = r_used; n_next_free = r_next_free;
        n_oldest = r_oldest; n_mapped = r_mapped; n_dirty = r_dirty; n_ref = r_ref;
        n_page = r_page; n_wr = r_wr; n_tick = r_tick; n_frame = r_frame; n_v = r_v;
        n_stat = r_stat; n_f = r_f; n_cnt = r_cnt; n_scan = r_scan; n_pv = r_pv;
        n_pp = r_pp; n_found = r_found; n_best = r_best; n_bidx = r_bidx; n_nf = r_nf;
        n_ni = r_ni; n_omod = r_omod; n_out = r_out; n_res = r_res;
        n_out_valid = r_out_valid && !i_rsp_ready;
        fop_we = 1'b0; fop_waddr = r_page; fop_wdata = r_frame; fop_raddr = r_v;
        pof_we = 1'b0; pof_waddr = r_frame; pof_wdata = r_page; pof_raddr = '0;
        age_we = 1'b0; age_waddr = r_pp; age_wdata = age_sum; age_raddr = sp;
        unique case (r_state)
            S_CLEAR: begin
                age_we    = 1'b1;
                age_waddr = sp;
                age_wdata = '0;
                if (int'(r_scan) == MAX_PAGES - 1) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_IDLE: begin
                fop_raddr = PW'(i_req.page);
                if (i_req_valid) begin
                    n_page = PW'(i_req.page);
                    n_wr   = i_req.is_write;
                    n_v    = '0;
                    if (int'(i_req.page) >= int'(np)) begin
                        n_res   = '{status: ST_INVALID, frame: 4'd0, evicted_page: 6'd0};
                        n_state = S_DONE;
                    end else begin
                        n_tick = (cnt >= {1'b0, r_period});
                        n_acc  = (cnt >= {1'b0, r_period}) ? 16'd0 : cnt[15:0];
                        if (r_mapped[PW'(i_req.page)]) begin
                            n_ref[PW'(i_req.page)] = 1'b1;
                            n_state = S_HIT;
                        end else if (int'(r_used) < int'(nf)) begin
                            n_frame     = r_next_free;
                            n_next_free = (int'(r_next_free) == MAX_FRAMES - 1) ?
                                          '0 : r_next_free + 1'b1;
                            n_used      = r_used + 1'b1;
                            n_stat      = ST_FREE;
                            n_state     = S_MAP;
                        end else begin
                            n_scan  = '0;
                            n_pv    = 1'b0;
                            n_found = 1'b0;
                            n_nf    = '0;
                            n_f     = r_oldest;
                            n_cnt   = '0;
                            case (r_policy)
                                POL_FIFO:   n_state = S_FIFO;
                                POL_SECOND: n_state = S_SC_MOD;
                                POL_NRU:    n_state = S_NRU;
                                default:    n_state = S_AGE;
                            endcase
                        end
                    end
                end
            end
            S_HIT: begin
                n_res   = '{status: ST_HIT, frame: 4'(fop_rdata), evicted_page: 6'd0};
                n_state = S_DONE;
            end
            S_FIFO: begin
                pof_raddr = (int'(r_oldest) < int'(r_used)) ? r_oldest : '0;
                n_state   = S_FIFOW;
            end
            S_FIFOW: begin
                n_v     = pof_rdata;
                n_state = S_EV_RD;
            end
            S_SC_MOD: begin
                if (int'(r_f) >= int'(nf)) begin
                    n_f = FW'(int'(r_f) - int'(nf));
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                pof_raddr = r_f;
                if (r_cnt == nf) begin
                    n_state = S_FIFO;
                end else if (int'(r_f) >= int'(r_used)) begin
                    n_f   = (int'(r_f) + 1 == int'(nf)) ? '0 : r_f + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (r_ref[pof_rdata]) begin
                    n_ref[pof_rdata] = 1'b0;
                    n_f     = (int'(r_f) + 1 == int'(nf)) ? '0 : r_f + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SC_RD;
                end else begin
                    n_v     = pof_rdata;
                    n_state = S_EV_RD;
                end
            end
            S_NRU: begin
                if (r_scan == np) begin
                    n_state = S_EV_RD;
                    if (r_nf[0])      n_v = r_ni[0];
                    else if (r_nf[1]) n_v = r_ni[1];
                    else if (r_nf[2]) n_v = r_ni[2];
                    else if (r_nf[3]) n_v = r_ni[3];
                    else              n_state = S_FIFO;
                end else begin
                    n_scan = r_scan + 1'b1;
                    if (r_mapped[sp]) begin
                        case ({r_ref[sp], r_dirty[sp]})
                            2'b00: if (!r_nf[0]) begin n_nf[0] = 1'b1; n_ni[0] = sp; end
                            2'b01: begin n_nf[1] = 1'b1; n_ni[1] = sp; end
                            2'b10: if (!r_nf[2]) begin n_nf[2] = 1'b1; n_ni[2] = sp; end
                            default: begin n_nf[3] = 1'b1; n_ni[3] = sp; end
                        endcase
                    end
                end
            end
            S_AGE: begin
                if (r_scan != np) begin
                    n_pp   = sp;
                    n_pv   = 1'b1;
                    n_scan = r_scan + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    age_we = r_tick;
                    if (r_mapped[r_pp] && (!r_found || age_sum < r_best)) begin
                        n_found = 1'b1;
                        n_best  = age_sum;
                        n_bidx  = r_pp;
                    end
                end else if (r_scan == np) begin
                    n_v     = r_bidx;
                    n_state = r_found ? S_EV_RD : S_FIFO;
                end
            end
            S_EV_RD: begin
                n_state = S_EV_WR;
            end
            S_EV_WR: begin
                n_frame       = fop_rdata;
                n_mapped[r_v] = 1'b0;
                n_dirty[r_v]  = 1'b0;
                n_ref[r_v]    = 1'b0;
                age_we        = 1'b1;
                age_waddr     = r_v;
                age_wdata     = '0;
                n_stat        = ST_EVICT;
                n_omod        = {1'b0, r_oldest} + 1'b1;
                n_state       = S_OMOD;
            end
            S_OMOD: begin
                if (int'(r_omod) >= int'(nf)) begin
                    n_omod = (FW+1)'(int'(r_omod) - int'(nf));
                end else begin
                    n_oldest = r_omod[FW-1:0];
                    n_state  = S_MAP;
                end
            end
            S_MAP: begin
                fop_we = 1'b1;
                pof_we = 1'b1;
                n_mapped[r_page] = 1'b1;
                if (r_wr) n_dirty[r_page] = 1'b1;
                n_ref[r_page] = 1'b1;
                if (r_tick) begin
                    for (int p = 0; p < MAX_PAGES; p++) begin
                        if (p < int'(np)) n_ref[p] = 1'b0;
                    end
                end
                n_res   = '{status: r_stat, frame: 4'(r_frame), evicted_page: 6'(r_v)};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_policy    <= POL_FIFO;
            r_pages     <= 7'd64;
            r_frames    <= 5'd16;
            r_period    <= 16'd1;
            r_acc       <= '0;
            r_used      <= '0;
            r_next_free <= '0;
            r_oldest    <= '0;
            r_mapped    <= '0;
            r_dirty     <= '0;
            r_ref       <= '0;
            r_scan      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_used      <= n_used;
            r_next_free <= n_next_free;
            r_oldest    <= n_oldest;
            r_mapped    <= n_mapped;
            r_dirty     <= n_dirty;
            r_ref       <= n_ref;
            r_scan      <= n_scan;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POLICY: r_policy <= i_cfg_data[1:0];
                    CFG_PAGES:  r_pages  <= i_cfg_data[6:0];
                    CFG_FRAMES: r_frames <= i_cfg_data[4:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default:    r_period <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_wr    <= n_wr;
        r_tick  <= n_tick;
        r_frame <= n_frame;
        r_v     <= n_v;
        r_stat  <= n_stat;
        r_f     <= n_f;
        r_cnt   <= n_cnt;
        r_pp    <= n_pp;
        r_found <= n_found;
        r_best  <= n_best;
        r_bidx  <= n_bidx;
        r_nf    <= n_nf;
        r_ni    <= n_ni;
        r_omod  <= n_omod;
        r_out   <= n_out;
        r_res   <= n_res;
    end

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= MAX_FRAMES)
        else $error("used frame count above frame capacity");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> r_state != S_IDLE)
        else $error("request accepted without starting work");

    a_evict_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_EVICT |-> o_rsp.evicted_page == 6'd0)
        else $error("evicted page reported without eviction");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pre_pkg::*;

    typedef struct {
        bit         is_cfg;
        logic [1:0] idx;
        logic [15:0] data;
        logic [5:0] pg;
        bit         wr;
        bit         typed;
        t_rsp       rsp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    page_replacement_engine dut (.*);

    always #5 i_clk = ~i_clk;

    // mirrored configuration and page table
    logic [1:0]  cur_policy = POL_FIFO;
    logic [6:0]  cur_pages = 7'd64;
    logic [4:0]  cur_frames = 5'd16;
    logic [15:0] cur_period = 16'd1;
    logic [3:0]  frame_of[64];
    bit          mapped[64];
    bit          dirty[64];
    bit          refd[64];
    logic [7:0]  age[64];
    logic [5:0]  page_in[16];
    int          used_cnt = 0;
    int          free_ptr = 0;
    int          oldest = 0;
    int          acc_cnt = 0;

    t_rsp        expected_rsp[$];
    int          errors = 0;
    bit          quiet = 0;
    bit          long_hold = 0;
    t_row        rows[$];

    task automatic report_err(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int fifo_pick();
        int f;
        f = (oldest < used_cnt) ? oldest : 0;
        return page_in[f % 16];
    endfunction

    function automatic t_rsp predict_access(logic [5:0] pg, bit wr);
        int np, nf, cnt, v, fr, f, c;
        bit tick;
        t_rsp r;
        r = '0;
        np = (cur_pages > 64) ? 64 : cur_pages;
        if (pg >= np) begin
            r.status = ST_INVALID;
            return r;
        end
        cnt = acc_cnt + 1;
        tick = (cnt >= cur_period);
        acc_cnt = tick ? 0 : (cnt & 16'hffff);
        if (mapped[pg]) begin
            refd[pg] = 1;
            r.status = ST_HIT;
            r.frame = frame_of[pg];
            return r;
        end
        nf = (cur_frames == 0) ? 1 : ((cur_frames > 16) ? 16 : cur_frames);
        if (used_cnt < nf) begin
            fr = free_ptr % 16;
            free_ptr = (fr + 1) % 16;
            used_cnt++;
            r.status = ST_FREE;
        end else begin
            v = -1;
            case (cur_policy)
                POL_FIFO: v = fifo_pick();
                POL_SECOND: begin
                    for (int i = 0; i < nf && v < 0; i++) begin
                        f = (oldest + i) % nf;
                        if (f < used_cnt) begin
                            if (refd[page_in[f]]) refd[page_in[f]] = 0;
                            else v = page_in[f];
                        end
                    end
                    if (v < 0) v = fifo_pick();
                end
                POL_NRU: begin
                    for (c = 0; c < 4 && v < 0; c++)
                        for (int i = 0; i < np && v < 0; i++) begin
                            f = c[0] ? (np - 1 - i) : i;
                            if (mapped[f] && refd[f] == c[1] && dirty[f] == c[0]) v = f;
                        end
                    if (v < 0) v = fifo_pick();
                end
                default: begin
                    if (tick)
                        for (int p = 0; p < np; p++) age[p] = age[p] + refd[p];
                    for (int p = 0; p < np; p++)
                        if (mapped[p] && (v < 0 || age[p] < age[v])) v = p;
                    if (v < 0) v = fifo_pick();
                end
            endcase
            v = v % 64;
            fr = frame_of[v];
            oldest = (oldest + 1) % nf;
            mapped[v] = 0;
            dirty[v] = 0;
            refd[v] = 0;
            age[v] = '0;
            r.status = ST_EVICT;
            r.evicted_page = v;
        end
        frame_of[pg] = fr;
        page_in[fr] = pg;
        mapped[pg] = 1;
        if (wr) dirty[pg] = 1;
        refd[pg] = 1;
        r.frame = fr;
        if (tick)
            for (int p = 0; p < np; p++) refd[p] = 0;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_req(logic [5:0] pg, bit wr, bit typed, t_rsp typed_rsp);
        int gap;
        t_rsp p;
        i_req_valid <= 1'b1;
        i_req <= '{page: pg, is_write: wr};
        do @(posedge i_clk); while (!o_req_ready);
        p = predict_access(pg, wr);
        expected_rsp.push_back(typed ? typed_rsp : p);
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POLICY: cur_policy = data[1:0];
            CFG_PAGES:  cur_pages = data[6:0];
            CFG_FRAMES: cur_frames = data[4:0];
            default:    cur_period = data;
        endcase
    endtask

    // response check
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_rsp.size() == 0) begin
                report_err("response with no request outstanding");
            end else begin
                e = expected_rsp.pop_front();
                if (o_rsp.status !== e.status)
                    report_err($sformatf("status %0d exp %0d", o_rsp.status, e.status));
                if (o_rsp.frame !== e.frame)
                    report_err($sformatf("frame %0d exp %0d", o_rsp.frame, e.frame));
                if (o_rsp.evicted_page !== e.evicted_page)
                    report_err($sformatf("evicted %0d exp %0d",
                        o_rsp.evicted_page, e.evicted_page));
            end
        end
    end

    // receiver stalls
    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 0;
                i_rsp_ready <= 1'b0;
                for (int n = 0; n < 600; n++) @(posedge i_clk);
            end else if (quiet) begin
                i_rsp_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_rsp_ready <= 1'b1;
                end else begin
                    i_rsp_ready <= 1'b0;
                    repeat ((r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40))
                        @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int np, hi;
        logic [15:0] d;
        foreach (mapped[i]) begin
            mapped[i] = 0; dirty[i] = 0; refd[i] = 0; age[i] = '0; frame_of[i] = '0;
        end
        foreach (page_in[i]) page_in[i] = '0;

        rows.push_back('{0, 0, 0, 6'd0,  1, 1, '{ST_FREE, 4'd0, 6'd0}});
        rows.push_back('{0, 0, 0, 6'd63, 0, 1, '{ST_FREE, 4'd1, 6'd0}});
        rows.push_back('{0, 0, 0, 6'd0,  0, 1, '{ST_HIT, 4'd0, 6'd0}});
        rows.push_back('{1, CFG_PAGES, 16'd10, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd63, 0, 1, '{ST_INVALID, 4'd0, 6'd0}});
        rows.push_back('{0, 0, 0, 6'd42, 0, 1, '{ST_INVALID, 4'd0, 6'd0}});
        rows.push_back('{0, 0, 0, 6'd21, 1, 1, '{ST_INVALID, 4'd0, 6'd0}});
        rows.push_back('{1, CFG_PAGES, 16'd0, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd0,  0, 1, '{ST_INVALID, 4'd0, 6'd0}});
        rows.push_back('{1, CFG_PAGES, 16'd127, 6'd0, 0, 0, '0});
        rows.push_back('{1, CFG_FRAMES, 16'd0, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd5,  1, 1, '{ST_EVICT, 4'd0, 6'd0}});
        rows.push_back('{1, CFG_POLICY, POL_SECOND, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd7,  0, 0, '0});
        rows.push_back('{1, CFG_POLICY, POL_NRU, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd9,  1, 0, '0});
        rows.push_back('{1, CFG_POLICY, POL_AGING, 6'd0, 0, 0, '0});
        rows.push_back('{1, CFG_PERIOD, 16'd0, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd11, 0, 0, '0});
        rows.push_back('{1, CFG_FRAMES, 16'd31, 6'd0, 0, 0, '0});
        rows.push_back('{1, CFG_PERIOD, 16'hffff, 6'd0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 6'd12, 1, 0, '0});
        rows.push_back('{0, 0, 0, 6'd11, 0, 0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) cfg_write(rows[i].idx, rows[i].data);
            else send_req(rows[i].pg, rows[i].wr, rows[i].typed, rows[i].rsp);
        end

        for (int ph = 0; ph < 14; ph++) begin
            cfg_write(CFG_POLICY, ph % 4);
            case ($urandom_range(0, 5))
                0: d = 16'd1;
                1: d = 16'd64;
                2: d = 16'd127;
                default: d = $urandom_range(2, 64);
            endcase
            if (ph == 9) d = 16'd0;
            cfg_write(CFG_PAGES, d);
            case ($urandom_range(0, 5))
                0: d = 16'd0;
                1: d = 16'd1;
                2: d = 16'd16;
                3: d = 16'd31;
                default: d = $urandom_range(2, 15);
            endcase
            cfg_write(CFG_FRAMES, d);
            case ($urandom_range(0, 5))
                0: d = 16'd0;
                1: d = 16'd1;
                2: d = 16'hffff;
                default: d = $urandom_range(2, 8);
            endcase
            cfg_write(CFG_PERIOD, d);
            quiet = (ph % 5 == 2);
            if (ph == 5) long_hold = 1;
            np = (cur_pages > 64) ? 64 : cur_pages;
            hi = (np + 3 > 63) ? 63 : np + 3;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 9) < 7)
                    send_req($urandom_range(0, hi), $urandom_range(0, 1), 0, '0);
                else
                    send_req($urandom_range(0, 63), $urandom_range(0, 1), 0, '0);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
